/* src/ule_pkg.sv */
`default_nettype none
package ule_pkg;

  localparam int BufferDepth = 256;
  localparam int QueueDepth = 4;

  // Longest line the buffer can hold, including the terminating zero.
  localparam int LineCapInt = (BufferDepth < 256) ? BufferDepth : 256;
  localparam logic [8:0] LineCap = 9'(LineCapInt);

  localparam logic [1:0] RegBackspaceA = 2'd0;
  localparam logic [1:0] RegBackspaceB = 2'd1;
  localparam logic [1:0] RegEnter = 2'd2;
  localparam logic [1:0] RegMaxLength = 2'd3;

  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;

  typedef enum logic [1:0] {
    CmdChar,
    CmdBackspace,
    CmdEnter
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic [7:0] data;
    logic [7:0] index;
    logic error;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bs_code_a;
    logic [7:0] bs_code_b;
    logic [7:0] enter_code;
    logic [8:0] len_limit;
  } cfg_t;

  typedef struct packed {
    logic tx_valid;
    logic [7:0] tx_byte;
    logic store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic line_done;
    logic [7:0] line_length;
    logic line_error;
    logic last;
  } result_t;

endpackage
`default_nettype wire

/* src/ule_front.sv */
`default_nettype none
module ule_front import ule_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o
);

  logic [7:0] fill_q, fill_d;
  logic       disc_q, disc_d;
  logic       is_enter, is_bs;
  logic [8:0] limit;

  always_comb begin
    if (cfg_i.len_limit == 9'd0) begin
      limit = 9'd1;
    end else if (cfg_i.len_limit > LineCap) begin
      limit = LineCap;
    end else begin
      limit = cfg_i.len_limit;
    end
  end

  assign is_enter = (rx_byte_i == cfg_i.enter_code);
  assign is_bs = (rx_byte_i == cfg_i.bs_code_a) || (rx_byte_i == cfg_i.bs_code_b);

  always_comb begin
    fill_d = fill_q;
    disc_d = disc_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind = CmdChar;
    cmd_o.data = rx_byte_i;
    cmd_o.index = fill_q;
    cmd_o.error = 1'b0;
    if (accept_i) begin
      priority if (disc_q) begin
        // While discarding, only the enter code is looked at.
        if (is_enter) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind = CmdEnter;
          cmd_o.error = 1'b1;
          fill_d = 8'd0;
          disc_d = 1'b0;
        end
      end else if (is_bs) begin
        if (fill_q != 8'd0) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind = CmdBackspace;
          fill_d = fill_q - 8'd1;
        end
      end else if (is_enter) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind = CmdEnter;
        fill_d = 8'd0;
      end else if ({1'b0, fill_q} >= limit - 9'd1) begin
        disc_d = 1'b1;
      end else begin
        cmd_valid_o = 1'b1;
        cmd_o.kind = CmdChar;
        fill_d = fill_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 8'd0;
      disc_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      disc_q <= disc_d;
    end
  end

endmodule
`default_nettype wire

/* src/ule_cmd_fifo.sv */
`default_nettype none
module ule_cmd_fifo import ule_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire cmd_t wr_data_i,
  input  wire logic rd_i,
  output cmd_t      rd_data_o,
  output logic      full_o,
  output logic      not_empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  cmd_t            entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o = (count_q == FullCnt);
  assign not_empty_o = (count_q != '0);
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && not_empty_o;
  assign rd_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntOne;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntOne;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ule_back.sv */
`default_nettype none
module ule_back import ule_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic pop_i,
  output logic      out_valid_o,
  output result_t   out_o
);

  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, res;
  logic       load;

  // One result per step of the command at the head of the queue.
  always_comb begin
    res = '0;
    res.tx_valid = 1'b1;
    unique case (cmd_i.kind)
      CmdChar: begin
        res.tx_byte = cmd_i.data;
        res.store_valid = 1'b1;
        res.store_index = cmd_i.index;
        res.store_byte = cmd_i.data;
        res.last = 1'b1;
      end
      CmdBackspace: begin
        res.tx_byte = (step_q == 2'd1) ? ChSp : ChBs;
        res.last = (step_q == 2'd2);
      end
      CmdEnter: begin
        if (step_q == 2'd0) begin
          res.tx_byte = ChCr;
        end else begin
          res.tx_byte = ChLf;
          res.store_valid = 1'b1;
          res.store_index = cmd_i.index;
          res.line_done = 1'b1;
          res.line_length = cmd_i.error ? 8'd0 : cmd_i.index;
          res.line_error = cmd_i.error;
          res.last = 1'b1;
        end
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  assign load = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = load && res.last;

  always_comb begin
    step_d = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      step_d = res.last ? 2'd0 : step_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule
`default_nettype wire

/* src/uart_line_editor.sv */
// Line editor for a terminal link. Received bytes are pushed into the input
// queue (push, full, rx_byte_i); echo and line buffer writes come out of the
// result queue (empty, pop) as one word per result, from one to three words
// per byte, with last_o marking the final word of a byte. Backspaces and
// bytes dropped on overflow may give no word at all.
// The key codes and the line length limit are set through the APB port at
// byte addresses 0, 4, 8 and 12; pready is always high.
// A byte is classified and the line state updated in the cycle it is
// accepted, so bytes are taken back to back until the command queue between
// the classifier and the result sequencer fills. The first word of a byte
// passes through the command queue and then the result register. The
// sequencer emits one word per cycle while pop is high.
// When pop stays low the result word holds, the command queue fills and
// full rises. Reset restores the default key codes, empties the line and
// both queues, and leaves the editor out of discard mode.
`default_nettype none
module uart_line_editor import ule_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             tx_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             store_valid_o,
  output logic [7:0]       store_index_o,
  output logic [7:0]       store_byte_o,
  output logic             line_done_o,
  output logic [7:0]       line_length_o,
  output logic             line_error_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bs_code_a <= 8'd127;
      cfg_q.bs_code_b <= 8'd8;
      cfg_q.enter_code <= 8'd13;
      cfg_q.len_limit <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBackspaceA: cfg_q.bs_code_a <= pwdata[7:0];
        RegBackspaceB: cfg_q.bs_code_b <= pwdata[7:0];
        RegEnter: cfg_q.enter_code <= pwdata[7:0];
        RegMaxLength: cfg_q.len_limit <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBackspaceA: prdata = {24'd0, cfg_q.bs_code_a};
      RegBackspaceB: prdata = {24'd0, cfg_q.bs_code_b};
      RegEnter: prdata = {24'd0, cfg_q.enter_code};
      RegMaxLength: prdata = {23'd0, cfg_q.len_limit};
      default: prdata = 32'd0;
    endcase
  end

  logic    accept;
  logic    front_valid;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    head_valid;
  logic    head_pop;
  logic    out_valid;
  result_t out_word;

  assign accept = push && !full;

  ule_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .cmd_valid_o(front_valid),
    .cmd_o      (front_cmd)
  );

  ule_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (front_valid),
    .wr_data_i  (front_cmd),
    .rd_i       (head_pop),
    .rd_data_o  (head_cmd),
    .full_o     (full),
    .not_empty_o(head_valid)
  );

  ule_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (head_pop),
    .pop_i      (pop),
    .out_valid_o(out_valid),
    .out_o      (out_word)
  );

  assign empty = !out_valid;
  assign tx_valid_o = out_word.tx_valid;
  assign tx_byte_o = out_word.tx_byte;
  assign store_valid_o = out_word.store_valid;
  assign store_index_o = out_word.store_index;
  assign store_byte_o = out_word.store_byte;
  assign line_done_o = out_word.line_done;
  assign line_length_o = out_word.line_length;
  assign line_error_o = out_word.line_error;
  assign last_o = out_word.last;

endmodule
`default_nettype wire

/* test/uart_line_editor_tb.sv */
`timescale 1ns / 100ps
module uart_line_editor_tb;
  import ule_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] rx_byte = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic tx_valid, store_valid, line_done, line_error, last_word;
  logic [7:0] tx_byte, store_index, store_byte, line_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic pready;

  // Predicted editor state and register copies.
  logic [7:0] cfg_bs_a = 8'd127;
  logic [7:0] cfg_bs_b = 8'd8;
  logic [7:0] cfg_enter = 8'd13;
  logic [8:0] cfg_len_limit = 9'd256;
  logic [7:0] line_fill = 8'd0;
  logic in_discard = 1'b0;

  result_t echo_words[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  uart_line_editor u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .rx_byte_i(rx_byte),
    .empty(empty),
    .pop(pop),
    .tx_valid_o(tx_valid),
    .tx_byte_o(tx_byte),
    .store_valid_o(store_valid),
    .store_index_o(store_index),
    .store_byte_o(store_byte),
    .line_done_o(line_done),
    .line_length_o(line_length),
    .line_error_o(line_error),
    .last_o(last_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic result_t make_word(input logic [7:0] tx, input logic st,
                                        input logic [7:0] idx, input logic [7:0] sb,
                                        input logic done, input logic [7:0] len,
                                        input logic err, input logic fin);
    result_t w;
    w.tx_valid = 1'b1;
    w.tx_byte = tx;
    w.store_valid = st;
    w.store_index = st ? idx : 8'd0;
    w.store_byte = st ? sb : 8'd0;
    w.line_done = done;
    w.line_length = done ? len : 8'd0;
    w.line_error = done & err;
    w.last = fin;
    return w;
  endfunction

  function automatic void predict_echo(input logic [7:0] b);
    logic is_enter;
    logic is_bs;
    logic [8:0] lim;
    is_enter = (b == cfg_enter);
    is_bs = (b == cfg_bs_a) || (b == cfg_bs_b);
    lim = cfg_len_limit;
    if (lim == 9'd0) lim = 9'd1;
    if (lim > LineCap) lim = LineCap;
    if (in_discard) begin
      // Only the enter code ends an overflowed line; everything else is dropped.
      if (is_enter) begin
        echo_words.push_back(make_word(ChCr, 0, 0, 0, 0, 0, 0, 0));
        echo_words.push_back(make_word(ChLf, 1, line_fill, 0, 1, 0, 1, 1));
        line_fill = 8'd0;
        in_discard = 1'b0;
      end
    end else if (is_bs) begin
      if (line_fill != 8'd0) begin
        echo_words.push_back(make_word(ChBs, 0, 0, 0, 0, 0, 0, 0));
        echo_words.push_back(make_word(ChSp, 0, 0, 0, 0, 0, 0, 0));
        echo_words.push_back(make_word(ChBs, 0, 0, 0, 0, 0, 0, 1));
        line_fill = line_fill - 8'd1;
      end
    end else if (is_enter) begin
      echo_words.push_back(make_word(ChCr, 0, 0, 0, 0, 0, 0, 0));
      echo_words.push_back(make_word(ChLf, 1, line_fill, 0, 1, line_fill, 0, 1));
      line_fill = 8'd0;
    end else if ({1'b0, line_fill} >= lim - 9'd1) begin
      in_discard = 1'b1;
    end else begin
      echo_words.push_back(make_word(b, 1, line_fill, b, 0, 0, 0, 1));
      line_fill = line_fill + 8'd1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    predict_echo(b);
  endtask

  // Lets the editor drain completely so the registers can be changed safely.
  task automatic wait_idle();
    push <= 1'b0;
    while (echo_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
    logic [31:0] expected;
    expected = (idx == RegMaxLength) ? {23'd0, value} : {24'd0, value[7:0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= expected;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegBackspaceA: cfg_bs_a = expected[7:0];
      RegBackspaceB: cfg_bs_b = expected[7:0];
      RegEnter: cfg_enter = expected[7:0];
      default: cfg_len_limit = expected[8:0];
    endcase
    // Read the register back.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== expected) begin
      $display("%0t: register %0d read expected %0h, got %0h", $time, idx, expected, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] bs_a, input logic [7:0] bs_b,
                           input logic [7:0] enter, input logic [8:0] max_len);
    write_reg(RegBackspaceA, {1'b0, bs_a});
    write_reg(RegBackspaceB, {1'b0, bs_b});
    write_reg(RegEnter, {1'b0, enter});
    write_reg(RegMaxLength, max_len);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == cfg_bs_a || c == cfg_bs_b || c == cfg_enter);
    return c;
  endfunction

  // Mostly typed text with backspaces and enters, plus a little noise.
  task automatic type_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 14) send_byte(cfg_bs_a);
      else if (pick < 24) send_byte(cfg_bs_b);
      else if (pick < 37) send_byte(cfg_enter);
      else if (pick < 42) send_byte(8'($urandom_range(255)));
      else send_byte(plain_char());
    end
  endtask

  task automatic test_default_codes();
    tx_idle_pct = 14;
    rx_idle_pct = 63;
    send_byte(8'h48);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'd8);
    send_byte(8'd127);
    send_byte(8'd127);
    // Backspace on an empty line echoes nothing.
    send_byte(8'd127);
    send_byte(8'd13);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'd13);
    wait_idle();
  endtask

  task automatic test_code_priority();
    set_codes(8'h41, 8'h00, 8'h41, 9'd2);
    // The shared code acts as a backspace while the line is being edited.
    send_byte(8'h78);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h79);
    send_byte(8'h7a);
    // While discarding, only the enter code is looked at.
    send_byte(8'h00);
    send_byte(8'h41);
    wait_idle();
  endtask

  task automatic test_length_limits();
    set_codes(8'hff, 8'h00, 8'h0d, 9'd0);
    // A zero limit behaves as one, so every character overflows.
    send_byte(8'h31);
    send_byte(8'h0d);
    wait_idle();
    write_reg(RegMaxLength, 9'd1);
    send_byte(8'h32);
    send_byte(8'h0d);
    send_byte(8'h0d);
    wait_idle();
    write_reg(RegMaxLength, 9'd8);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h64);
    wait_idle();
    // Shrinking the limit in mid-line still bounds the line.
    write_reg(RegMaxLength, 9'd3);
    send_byte(8'h65);
    send_byte(8'hff);
    send_byte(8'h0d);
    wait_idle();
  endtask

  task automatic test_random_slow_reader();
    tx_idle_pct = 14;
    rx_idle_pct = 63;
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              9'($urandom_range(24)));
    type_random(20);
    wait_idle();
  endtask

  task automatic test_random_slow_writer();
    tx_idle_pct = 63;
    rx_idle_pct = 14;
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              9'($urandom_range(2, 40)));
    type_random(20);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_codes(8'd127, 8'd8, 8'd13, 9'd256);
    // The reader stalls for a long stretch while bytes keep arriving.
    hold_request = 300;
    type_random(20);
    wait_idle();
  endtask

  task automatic test_full_line();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // An oversize limit is clamped to the buffer size.
    set_codes(8'd127, 8'd8, 8'd13, 9'h1ff);
    for (int n = 0; n < 256; n++) send_byte(plain_char());
    send_byte(8'd8);
    send_byte(8'd13);
    wait_idle();
  endtask

  task automatic test_random_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              9'($urandom_range(1, 16)));
    type_random(20);
    wait_idle();
  endtask

  // Takes result words and compares them with the oldest prediction.
  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] got);
    if (got !== exp) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (echo_words.size() == 0) begin
          $display("%0t: unexpected word expected none, got tx %0h", $time, tx_byte);
          errors++;
        end else begin
          w = echo_words.pop_front();
          check_field("tx_valid", w.tx_valid, tx_valid);
          check_field("tx_byte", w.tx_byte, tx_byte);
          check_field("store_valid", w.store_valid, store_valid);
          check_field("store_index", w.store_index, store_index);
          check_field("store_byte", w.store_byte, store_byte);
          check_field("line_done", w.line_done, line_done);
          check_field("line_length", w.line_length, line_length);
          check_field("line_error", w.line_error, line_error);
          check_field("last", w.last, last_word);
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || psel) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_codes();
    test_code_priority();
    test_length_limits();
    test_random_slow_reader();
    test_random_slow_writer();
    test_backpressure();
    test_full_line();
    test_random_no_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (echo_words.size() != 0) begin
      $display("%0t: leftover words expected 0, got %0d", $time, echo_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
